// ===== design/tbcr_pkg.sv =====
// Shared types and constants for the tile map box collision resolver.
// No dependencies.
package tbcr_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int TILE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int IDX_W      = $clog2(TILE_DEPTH);

    // coordinate width for tile centres and differences
    localparam int C_W    = 30;
    localparam int APB_AW = 5;
    localparam int TPR_W  = 7;

    localparam logic [2:0] REG_TILE_W = 3'd0;
    localparam logic [2:0] REG_TILE_H = 3'd1;
    localparam logic [2:0] REG_TPR    = 3'd2;
    localparam logic [2:0] REG_TPC    = 3'd3;
    localparam logic [2:0] REG_ORG_X  = 3'd4;
    localparam logic [2:0] REG_ORG_Y  = 3'd5;
    localparam logic [2:0] REG_SOLID  = 3'd6;

    typedef struct packed {
        logic [10:0]        tile_w;
        logic [10:0]        tile_h;
        logic [TPR_W-1:0]   tpr;
        logic [TPR_W-1:0]   tpc;
        logic signed [23:0] org_x;
        logic signed [23:0] org_y;
        logic [7:0]         solid;
    } t_cfg;

    typedef struct packed {
        logic wr_tile;
        logic init;
        logic diff;
        logic mag;
        logic pen;
        logic push;
        logic step;
        logic new_row;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_MAG,
        S_PEN,
        S_PUSH,
        S_DONE
    } t_state;

endpackage

// ===== design/tbcr_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on tbcr_pkg.
module tbcr_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tbcr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output tbcr_pkg::t_cfg             o_cfg
);
    import tbcr_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_w <= 11'd16;
            r_cfg.tile_h <= 11'd16;
            r_cfg.tpr    <= TPR_W'(64);
            r_cfg.tpc    <= TPR_W'(64);
            r_cfg.org_x  <= '0;
            r_cfg.org_y  <= '0;
            r_cfg.solid  <= 8'd2;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TILE_W: r_cfg.tile_w <= pwdata[10:0];
                REG_TILE_H: r_cfg.tile_h <= pwdata[10:0];
                REG_TPR:    r_cfg.tpr    <= pwdata[TPR_W-1:0];
                REG_TPC:    r_cfg.tpc    <= pwdata[TPR_W-1:0];
                REG_ORG_X:  r_cfg.org_x  <= pwdata[23:0];
                REG_ORG_Y:  r_cfg.org_y  <= pwdata[23:0];
                REG_SOLID:  r_cfg.solid  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TILE_W: prdata = 32'(r_cfg.tile_w);
            REG_TILE_H: prdata = 32'(r_cfg.tile_h);
            REG_TPR:    prdata = 32'(r_cfg.tpr);
            REG_TPC:    prdata = 32'(r_cfg.tpc);
            REG_ORG_X:  prdata = 32'(unsigned'(r_cfg.org_x));
            REG_ORG_Y:  prdata = 32'(unsigned'(r_cfg.org_y));
            REG_SOLID:  prdata = 32'(r_cfg.solid);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== design/tbcr_ctrl.sv =====
// Sequencer: walks the tile grid and issues datapath commands.
// Depends on tbcr_pkg.
module tbcr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_func,
    input  tbcr_pkg::t_cfg i_cfg,
    input  logic           i_solid,
    output tbcr_pkg::t_cmd o_cmd,
    output logic           busy,
    output logic           o_valid
);
    import tbcr_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [TPR_W-1:0] r_col;
    logic [TPR_W-1:0] r_row;
    logic [TPR_W-1:0] cols;
    logic [TPR_W-1:0] rows;
    logic             col_last;
    logic             last;
    logic             take;

    assign cols = (int'(i_cfg.tpr) > MAX_COLS) ? TPR_W'(MAX_COLS) : i_cfg.tpr;
    assign rows = (int'(i_cfg.tpc) > MAX_ROWS) ? TPR_W'(MAX_ROWS) : i_cfg.tpc;
    assign col_last = (r_col == cols - TPR_W'(1));
    assign last     = col_last && (r_row == rows - TPR_W'(1));
    assign busy     = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_DONE);
    assign take     = start && !busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (take && i_func) begin
                    n_state = (cols == '0 || rows == '0) ? S_DONE : S_RD;
                end
            end
            S_RD:   n_state = S_CHK;
            S_CHK: begin
                if (i_solid) begin
                    n_state = S_MAG;
                end else begin
                    n_state = last ? S_DONE : S_RD;
                end
            end
            S_MAG:  n_state = S_PEN;
            S_PEN:  n_state = S_PUSH;
            S_PUSH: n_state = last ? S_DONE : S_RD;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.wr_tile = take && !i_func;
                o_cmd.init    = take && i_func;
            end
            S_CHK: begin
                o_cmd.diff    = i_solid;
                o_cmd.step    = !i_solid;
                o_cmd.new_row = !i_solid && col_last;
            end
            S_MAG:  o_cmd.mag = 1'b1;
            S_PEN:  o_cmd.pen = 1'b1;
            S_PUSH: begin
                o_cmd.push    = 1'b1;
                o_cmd.step    = 1'b1;
                o_cmd.new_row = col_last;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.init) begin
                r_col <= '0;
                r_row <= '0;
            end else if (o_cmd.step) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= r_row + TPR_W'(1);
                end else begin
                    r_col <= r_col + TPR_W'(1);
                end
            end
        end
    end

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held over two cycles");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_func) |=> !busy)
        else $error("tile load left the block busy");

    a_resolve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_func) |=> busy)
        else $error("resolve beat not started");

    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_col < cols && r_row < rows))
        else $error("tile walk beyond grid");

endmodule

// ===== design/tbcr_dp.sv =====
// Datapath: tile kind memory, tile centre walk, overlap and push arithmetic.
// Depends on tbcr_pkg.
module tbcr_dp (
    input  logic               i_clk,
    input  tbcr_pkg::t_cfg     i_cfg,
    input  tbcr_pkg::t_cmd     i_cmd,
    input  logic [11:0]        i_tile_slot,
    input  logic [7:0]         i_tile_kind,
    input  logic signed [23:0] i_entity_x,
    input  logic signed [23:0] i_entity_y,
    input  logic [22:0]        i_box_width,
    input  logic [22:0]        i_box_height,
    output logic               o_solid,
    output logic signed [23:0] o_new_x,
    output logic signed [23:0] o_new_y,
    output logic               o_hit_top,
    output logic               o_hit_bottom,
    output logic               o_hit_left,
    output logic               o_hit_right
);
    import tbcr_pkg::*;

    function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        hi = 26'sd8388607;
        lo = -26'sd8388608;
        if (v > hi) begin
            sat24 = 24'sh7FFFFF;
        end else if (v < lo) begin
            sat24 = 24'sh800000;
        end else begin
            sat24 = v[23:0];
        end
    endfunction

    logic [7:0]           r_mem [TILE_DEPTH];
    logic [7:0]           r_rdata;
    logic [IDX_W-1:0]     r_idx;
    logic signed [23:0]   r_ex;
    logic signed [23:0]   r_ey;
    logic [22:0]          r_rx;
    logic [22:0]          r_ry;
    logic signed [C_W-1:0] r_cx;
    logic signed [C_W-1:0] r_cy;
    logic signed [C_W-1:0] r_dx;
    logic signed [C_W-1:0] r_dy;
    logic signed [C_W-1:0] r_mx;
    logic signed [C_W-1:0] r_my;
    logic                 r_ltx;
    logic                 r_lty;
    logic [22:0]          r_px;
    logic [22:0]          r_py;
    logic                 r_ov;
    logic                 r_top;
    logic                 r_bot;
    logic                 r_left;
    logic                 r_right;

    logic signed [C_W-1:0] step_x;
    logic signed [C_W-1:0] step_y;
    logic signed [C_W-1:0] htw;
    logic signed [C_W-1:0] hth;
    logic signed [C_W-1:0] row_cx;
    logic signed [C_W-1:0] cy0;
    logic signed [C_W-1:0] pdx;
    logic signed [C_W-1:0] pdy;
    logic                  wr_ok;
    logic                  y_axis;
    logic signed [23:0]    pos;
    logic [22:0]           amt;
    logic                  dec;
    logic signed [25:0]    moved;
    logic signed [23:0]    moved_sat;

    assign step_x = C_W'({i_cfg.tile_w, 8'h00});
    assign step_y = C_W'({i_cfg.tile_h, 8'h00});
    assign htw    = C_W'({i_cfg.tile_w[10:1], 8'h00});
    assign hth    = C_W'({i_cfg.tile_h[10:1], 8'h00});
    assign row_cx = C_W'($signed(i_cfg.org_x)) + htw;
    assign cy0    = C_W'($signed(i_cfg.org_y)) - hth;
    assign wr_ok  = (int'(i_tile_slot) < TILE_DEPTH);
    assign o_solid = (r_rdata == i_cfg.solid);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_tile && wr_ok) begin
            r_mem[IDX_W'(i_tile_slot)] <= i_tile_kind;
        end
        r_rdata <= r_mem[r_idx];
    end

    assign pdx = C_W'(r_rx) - r_mx;
    assign pdy = C_W'(r_ry) - r_my;

    assign y_axis    = (r_px > r_py);
    assign pos       = y_axis ? r_ey : r_ex;
    assign amt       = y_axis ? r_py : r_px;
    assign dec       = y_axis ? r_lty : r_ltx;
    assign moved     = dec ? (26'(pos) - 26'(amt)) : (26'(pos) + 26'(amt));
    assign moved_sat = sat24(moved);

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_ex    <= i_entity_x;
            r_ey    <= i_entity_y;
            r_rx    <= 23'(i_box_width[22:1])  + 23'({i_cfg.tile_w[10:1], 8'h00});
            r_ry    <= 23'(i_box_height[22:1]) + 23'({i_cfg.tile_h[10:1], 8'h00});
            r_cx    <= row_cx;
            r_cy    <= cy0;
            r_idx   <= '0;
            r_top   <= 1'b0;
            r_bot   <= 1'b0;
            r_left  <= 1'b0;
            r_right <= 1'b0;
        end else begin
            if (i_cmd.diff) begin
                r_dx <= r_cx - C_W'(r_ex);
                r_dy <= r_cy - C_W'(r_ey);
            end
            if (i_cmd.mag) begin
                r_mx  <= r_dx[C_W-1] ? -r_dx : r_dx;
                r_my  <= r_dy[C_W-1] ? -r_dy : r_dy;
                r_ltx <= !r_dx[C_W-1] && (r_dx != '0);
                r_lty <= !r_dy[C_W-1] && (r_dy != '0);
            end
            if (i_cmd.pen) begin
                r_px <= pdx[22:0];
                r_py <= pdy[22:0];
                r_ov <= !pdx[C_W-1] && (pdx != '0) && !pdy[C_W-1] && (pdy != '0);
            end
            if (i_cmd.push && r_ov) begin
                if (y_axis) begin
                    r_ey <= moved_sat;
                    if (r_lty) begin
                        r_top <= 1'b1;
                    end else begin
                        r_bot <= 1'b1;
                    end
                end else begin
                    r_ex <= moved_sat;
                    if (r_ltx) begin
                        r_right <= 1'b1;
                    end else begin
                        r_left <= 1'b1;
                    end
                end
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + IDX_W'(1);
                if (i_cmd.new_row) begin
                    r_cx <= row_cx;
                    r_cy <= r_cy - step_y;
                end else begin
                    r_cx <= r_cx + step_x;
                end
            end
        end
    end

    assign o_new_x      = r_ex;
    assign o_new_y      = r_ey;
    assign o_hit_top    = r_top;
    assign o_hit_bottom = r_bot;
    assign o_hit_left   = r_left;
    assign o_hit_right  = r_right;

endmodule

// ===== design/tilemap_box_collision_resolve_top.sv =====
// Top level of the tile map box collision resolver.
// Depends on tbcr_pkg, tbcr_regs, tbcr_ctrl and tbcr_dp.
//
// A load beat (i_func low) writes one tile kind in the cycle it is taken and
// leaves busy low, so loads may follow back to back. A resolve beat (i_func
// high) walks the grid row by row, one tile at a time through the tile
// memory: each tile passes through the read and check states, and a tile whose
// kind is the solid code then through the magnitude, penetration and push
// states; after the last tile the done state shows the result. The result is
// shown for exactly one cycle with o_valid high and cannot be held off; busy
// is still high in that cycle and falls in the next. Configuration writes
// belong only to idle periods.
module tilemap_box_collision_resolve_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_func,
    input  logic [11:0]                 i_tile_slot,
    input  logic [7:0]                  i_tile_kind,
    input  logic signed [23:0]          i_entity_x,
    input  logic signed [23:0]          i_entity_y,
    input  logic [22:0]                 i_box_width,
    input  logic [22:0]                 i_box_height,
    output logic                        o_valid,
    output logic signed [23:0]          o_new_x,
    output logic signed [23:0]          o_new_y,
    output logic                        o_hit_top,
    output logic                        o_hit_bottom,
    output logic                        o_hit_left,
    output logic                        o_hit_right,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tbcr_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tbcr_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    logic solid;

    tbcr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tbcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_cfg   (cfg),
        .i_solid (solid),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    tbcr_dp u_dp (
        .i_clk        (i_clk),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .i_tile_slot  (i_tile_slot),
        .i_tile_kind  (i_tile_kind),
        .i_entity_x   (i_entity_x),
        .i_entity_y   (i_entity_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .o_solid      (solid),
        .o_new_x      (o_new_x),
        .o_new_y      (o_new_y),
        .o_hit_top    (o_hit_top),
        .o_hit_bottom (o_hit_bottom),
        .o_hit_left   (o_hit_left),
        .o_hit_right  (o_hit_right)
    );

endmodule
